[hdl/sha1md_pkg.sv]
// shared types and constants for the sha-1 message digest core
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned WSEL_W      = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [ROUND_W-1:0] PHASE1_END = 7'd20;
    localparam logic [ROUND_W-1:0] PHASE2_END = 7'd40;
    localparam logic [ROUND_W-1:0] PHASE3_END = 7'd60;

    localparam logic [POS_W-1:0]  LAST_POS   = 6'd63;
    localparam logic [POS_W-1:0]  LEN_LIMIT  = 6'd56;
    localparam logic [WSEL_W-1:0] LAST_WORD  = 3'd4;

    localparam int unsigned LEN_HI_WORD = 14;
    localparam int unsigned LEN_LO_WORD = 15;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] INIT_CHAIN [0:CHAIN_WORDS-1] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_PHASE1 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PHASE2 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_PHASE3 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PHASE4 = 32'hCA62C1D6;

    typedef struct packed {
        logic                absorb;
        logic                pad;
        logic                put_len;
        logic                len_only;
        logic                load_work;
        logic                round;
        logic                chain_add;
        logic                clear;
        logic [ROUND_W-1:0]  round_idx;
        logic [WSEL_W-1:0]   word_sel;
    } sha1md_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } sha1md_status_t;

endpackage

[hdl/sha1md_ctrl.sv]
// sequencer for byte loading, padding, compression rounds and digest output
`timescale 1ns / 1ps

module sha1md_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     byte_valid,
    input  logic                     end_of_message,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               word_index,
    output logic                     last_word,
    output sha1md_pkg::sha1md_cmd_t  cmd,
    input  sha1md_pkg::sha1md_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PAD2,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_BLOCK,
        PH_EXTRA,
        PH_LAST
    } phase_t;

    state_t                            state_reg, state_next;
    phase_t                            phase_reg, phase_next;
    logic [sha1md_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [sha1md_pkg::WSEL_W-1:0]     word_reg, word_next;
    logic                              end_pend_reg, end_pend_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        end_pend_next = end_pend_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        cmd.word_sel  = word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.absorb = 1'b1;
                    end
                    if (byte_valid && status.pos == sha1md_pkg::LAST_POS)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        phase_next    = PH_BLOCK;
                        end_pend_next = end_of_message;
                        state_next    = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.pad       = 1'b1;
                cmd.put_len   = status.pos < sha1md_pkg::LEN_LIMIT;
                cmd.load_work = 1'b1;
                round_next    = '0;
                phase_next    = cmd.put_len ? PH_LAST : PH_EXTRA;
                state_next    = ST_ROUND;
            end
            ST_PAD2:
            begin
                cmd.len_only  = 1'b1;
                cmd.load_work = 1'b1;
                round_next    = '0;
                phase_next    = PH_LAST;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == sha1md_pkg::LAST_ROUND)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.chain_add = 1'b1;
                case (phase_reg)
                    PH_BLOCK:
                    begin
                        end_pend_next = 1'b0;
                        state_next    = end_pend_reg ? ST_PAD : ST_IDLE;
                    end
                    PH_EXTRA:
                    begin
                        state_next = ST_PAD2;
                    end
                    PH_LAST:
                    begin
                        word_next  = '0;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (word_reg == sha1md_pkg::LAST_WORD)
                    begin
                        cmd.clear     = 1'b1;
                        end_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_BLOCK;
            round_reg    <= '0;
            word_reg     <= '0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            round_reg    <= round_next;
            word_reg     <= word_next;
            end_pend_reg <= end_pend_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = word_reg;
    assign last_word  = (word_reg == sha1md_pkg::LAST_WORD);

endmodule

[hdl/sha1md_dp.sv]
// block buffer, message schedule, round logic, chaining words and byte count
`timescale 1ns / 1ps

module sha1md_dp
#(
    parameter int unsigned LENGTH_BITS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 data_byte,
    input  sha1md_pkg::sha1md_cmd_t    cmd,
    output sha1md_pkg::sha1md_status_t status,
    output logic [31:0]                digest_word
);

    logic [31:0] chain_reg [0:sha1md_pkg::CHAIN_WORDS-1];
    logic [31:0] work_reg  [0:sha1md_pkg::CHAIN_WORDS-1];
    logic [31:0] work_next [0:sha1md_pkg::CHAIN_WORDS-1];
    logic [31:0] blk_reg   [0:sha1md_pkg::BLOCK_WORDS-1];
    logic [31:0] blk_next  [0:sha1md_pkg::BLOCK_WORDS-1];
    logic [sha1md_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [sha1md_pkg::POS_W-1:0] pos;
    logic [4:0]                   lane_sh;
    logic [63:0]                  bit_len;
    logic [63:0]                  len_field;
    logic [31:0]                  f_val;
    logic [31:0]                  k_val;
    logic [31:0]                  temp;
    logic [31:0]                  sched_new;
    logic [5:0]                   byte_i;

    assign pos        = count_reg[sha1md_pkg::POS_W-1:0];
    assign status.pos = pos;
    assign lane_sh    = {~pos[1:0], 3'b000};

    // message bit length, truncated to the length width and zero extended
    assign bit_len   = {count_reg, 3'b000};
    assign len_field = 64'(bit_len[LENGTH_BITS-1:0]);

    // round function and constant
    always_comb
    begin
        if (cmd.round_idx < sha1md_pkg::PHASE1_END)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = sha1md_pkg::K_PHASE1;
        end
        else if (cmd.round_idx < sha1md_pkg::PHASE2_END)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K_PHASE2;
        end
        else if (cmd.round_idx < sha1md_pkg::PHASE3_END)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = sha1md_pkg::K_PHASE3;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K_PHASE4;
        end
    end

    assign temp = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4]
                + k_val + blk_reg[0];

    // schedule word w[t+16], entering at the end of the block buffer
    always_comb
    begin
        sched_new = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
        sched_new = {sched_new[30:0], sched_new[31]};
    end

    always_comb
    begin
        for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
        begin
            work_next[i] = work_reg[i];
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
            begin
                work_next[i] = chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_next[4] = work_reg[3];
            work_next[3] = work_reg[2];
            work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
            work_next[1] = work_reg[0];
            work_next[0] = temp;
        end
    end

    always_comb
    begin
        byte_i = '0;
        for (int w = 0; w < sha1md_pkg::BLOCK_WORDS; w++)
        begin
            blk_next[w] = blk_reg[w];
        end
        if (cmd.absorb)
        begin
            blk_next[pos[5:2]][lane_sh +: 8] = data_byte;
        end
        if (cmd.pad)
        begin
            for (int w = 0; w < sha1md_pkg::BLOCK_WORDS; w++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    byte_i = {4'(w), 2'(l)};
                    if (byte_i == pos)
                    begin
                        blk_next[w][8*(3-l) +: 8] = sha1md_pkg::PAD_BYTE;
                    end
                    else if (byte_i > pos)
                    begin
                        blk_next[w][8*(3-l) +: 8] = 8'h00;
                    end
                end
            end
            if (cmd.put_len)
            begin
                blk_next[sha1md_pkg::LEN_HI_WORD] = len_field[63:32];
                blk_next[sha1md_pkg::LEN_LO_WORD] = len_field[31:0];
            end
        end
        if (cmd.len_only)
        begin
            for (int w = 0; w < sha1md_pkg::BLOCK_WORDS; w++)
            begin
                blk_next[w] = '0;
            end
            blk_next[sha1md_pkg::LEN_HI_WORD] = len_field[63:32];
            blk_next[sha1md_pkg::LEN_LO_WORD] = len_field[31:0];
        end
        if (cmd.round)
        begin
            for (int w = 0; w < sha1md_pkg::BLOCK_WORDS - 1; w++)
            begin
                blk_next[w] = blk_reg[w+1];
            end
            blk_next[sha1md_pkg::BLOCK_WORDS-1] = sched_new;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.absorb)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < sha1md_pkg::BLOCK_WORDS; w++)
        begin
            blk_reg[w] <= blk_next[w];
        end
        for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
        begin
            work_reg[i] <= work_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= sha1md_pkg::INIT_CHAIN[i];
            end
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear)
            begin
                for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
                begin
                    chain_reg[i] <= sha1md_pkg::INIT_CHAIN[i];
                end
            end
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    assign digest_word = chain_reg[cmd.word_sel];

endmodule

[hdl/sha1_message_digest_core.sv]
// sha-1 message digest core, top level
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  data_byte, byte_valid, end_of_message
//  output    out        out_valid / out_stall digest_word, word_index, last_word
//
//  a request without end of message stores its byte, if byte_valid; one that fills a 64-byte block then
//  takes 80 rounds of the single round unit plus a load and a chaining add
//  a final request adds one or two padding blocks, then 5 output requests
//  no clearing pass after reset; the core takes requests in the first cycle out of reset
//  in_stall is high from the cycle after a block fills or a message ends until the block is chained in,
//  or for the last block until the last digest word leaves; out_stall holds the current digest word and its index
`timescale 1ns / 1ps

module sha1_message_digest_core
#(
    parameter int unsigned LENGTH_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1md_pkg::sha1md_cmd_t    cmd;
    sha1md_pkg::sha1md_status_t status;

    sha1md_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .cmd            (cmd),
        .status         (status)
    );

    sha1md_dp
    #(
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

[hdl/sha1md_chk.sv]
// port-level checker for the sha-1 message digest core, with its bind
`timescale 1ns / 1ps

module sha1md_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word
        |=> out_valid && (word_index == 3'($past(word_index) + 3'd1)))
        else $error("digest words not delivered in order");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest pending");

    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !in_stall && !out_valid)
        else $error("core not ready after last digest word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_core sha1md_chk u_sha1md_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
